### hdl/operator_token_lexer_top_defines.svh
// ----------------------------------------------------------------------------
// Operator token lexer assertion macros
// Shared property wrappers used by the lexer's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef OPERATOR_TOKEN_LEXER_TOP_DEFINES_SVH
`define OPERATOR_TOKEN_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/otl_pkg.sv
// ----------------------------------------------------------------------------
// Operator token lexer package
// Character tables, token class codes, scan phases and shared structs.
// ----------------------------------------------------------------------------
package otl_pkg;

    localparam int ASCII_OP_COUNT = 19;
    localparam int UNI_OP_COUNT   = 21;

    // ASCII operator characters and their precedence classes.
    localparam logic [6:0] ASCII_OPS [ASCII_OP_COUNT] = '{
        7'h24, 7'h5E, 7'h2A, 7'h25, 7'h5C, 7'h2F, 7'h2B, 7'h2D, 7'h7E, 7'h7C,
        7'h26, 7'h2E, 7'h3D, 7'h3C, 7'h3E, 7'h21, 7'h40, 7'h3A, 7'h3F
    };
    localparam logic [3:0] ASCII_CLS [ASCII_OP_COUNT] = '{
        4'd0, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7
    };

    // Unicode operator characters; the first thirteen are multiplicative.
    localparam logic [20:0] UNI_OPS [UNI_OP_COUNT] = '{
        21'h02219, 21'h02218, 21'h000D7, 21'h02605, 21'h02297, 21'h02298,
        21'h02299, 21'h0229B, 21'h022A0, 21'h022A1, 21'h02229, 21'h02227,
        21'h02293, 21'h000B1, 21'h02295, 21'h02296, 21'h0229E, 21'h0229F,
        21'h0222A, 21'h02228, 21'h02294
    };
    localparam logic [3:0] UNI_CLS [UNI_OP_COUNT] = '{
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3
    };

    // Characters with a role in the scan.
    localparam logic [20:0] CH_DOT   = 21'h2E;
    localparam logic [20:0] CH_EQ    = 21'h3D;
    localparam logic [20:0] CH_COLON = 21'h3A;
    localparam logic [20:0] CH_GT    = 21'h3E;
    localparam logic [20:0] CH_LT    = 21'h3C;
    localparam logic [20:0] CH_BANG  = 21'h21;
    localparam logic [20:0] CH_QUEST = 21'h3F;
    localparam logic [20:0] CH_TILDE = 21'h7E;
    localparam logic [20:0] CH_MINUS = 21'h2D;
    localparam logic [20:0] CH_SPACE = 21'h20;
    localparam logic [20:0] CH_LF    = 21'h0A;
    localparam logic [20:0] CH_CR    = 21'h0D;

    // Token classes beyond the table classes.
    localparam logic [3:0] CLS_OP1   = 4'd8;
    localparam logic [3:0] CLS_OP0   = 4'd9;
    localparam logic [3:0] CLS_EQUAL = 4'd10;
    localparam logic [3:0] CLS_COLON = 4'd11;
    localparam logic [3:0] CLS_NONE  = 4'd15;

    typedef enum logic [6:0] {
        PH_ARROW       = 7'b0000001,
        PH_ASSIGN      = 7'b0000010,
        PH_COLON       = 7'b0000100,
        PH_EQUAL       = 7'b0001000,
        PH_MAYBE_ARROW = 7'b0010000,
        PH_MAYBE_DOT   = 7'b0100000,
        PH_REGULAR     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic        start_req;
        logic [20:0] code_point;
        logic        immediate;
        logic        ops_all_valid;
        logic        equal_valid;
        logic        colon_valid;
    } item_t;

    typedef struct packed {
        logic imm;
        logic eq;
        logic col;
    } flags_t;

    typedef struct packed {
        logic       emit;
        logic       accepted;
        logic [3:0] token_class;
        logic [7:0] token_length;
    } result_t;

endpackage

### hdl/operator_token_lexer_top.sv
// Results are registered: a request passes from the input register through the
// classifier and the scan phase update into the result register. Throughput: one
// request per cycle, set by that single pass; a request that ends a scan waits in
// the input register while an earlier result stalls.
// Reset: rst_n clears the valid bits of both register stages and leaves the scanner
// idle in the regular phase with a zero count; no scan is open after reset.
// ----------------------------------------------------------------------------
// Operator token lexer top level
// Input register, classifier, scan state machine and result register.
// ----------------------------------------------------------------------------
`include "operator_token_lexer_top_defines.svh"

module operator_token_lexer_top #(
    parameter int unsigned MAX_LEN = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        start_req,
    input  logic [20:0] code_point,
    input  logic        immediate,
    input  logic        ops_all_valid,
    input  logic        equal_valid,
    input  logic        colon_valid,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        accepted,
    output logic [3:0]  token_class,
    output logic [7:0]  token_length
);
    import otl_pkg::*;

    item_t      item_reg;
    logic       item_vld_reg;
    logic       out_vld_reg;
    logic       acc_reg;
    logic [3:0] cls_reg;
    logic [7:0] len_reg;

    logic       out_free;
    logic       fire;
    logic [3:0] op_class;
    result_t    res;

    otl_classify u_classify (
        .code_point (item_reg.code_point),
        .op_class   (op_class)
    );

    otl_scan #(
        .MAX_LEN (MAX_LEN)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_fire (fire),
        .item      (item_reg),
        .op_class  (op_class),
        .res       (res)
    );

    // A request that produces no result never waits on the output side.
    assign out_free   = !out_vld_reg || !result_stall;
    assign fire       = item_vld_reg && (!res.emit || out_free);
    assign item_stall = item_vld_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= '{start_req: start_req, code_point: code_point,
                          immediate: immediate, ops_all_valid: ops_all_valid,
                          equal_valid: equal_valid, colon_valid: colon_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire && res.emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.emit)
        begin
            acc_reg <= res.accepted;
            cls_reg <= res.token_class;
            len_reg <= res.token_length;
        end
    end

    assign result_valid = out_vld_reg;
    assign accepted     = acc_reg;
    assign token_class  = cls_reg;
    assign token_length = len_reg;

    `OTL_ASSERT_IMP(a_reject_zero, clk, rst_n,
        out_vld_reg && !acc_reg,
        (cls_reg == 4'd0) && (len_reg == 8'd0),
        "rejected result carries a class or length")
    `OTL_ASSERT_IMP(a_accept_len, clk, rst_n,
        out_vld_reg && acc_reg,
        (len_reg != 8'd0) && (cls_reg <= CLS_COLON),
        "accepted result has empty length or bad class")
    `OTL_ASSERT_NXT(a_emit_lands, clk, rst_n,
        fire && res.emit,
        out_vld_reg,
        "emitted result did not reach the output register")

endmodule

### hdl/otl_classify.sv
// ----------------------------------------------------------------------------
// Operator character classifier
// Maps a code point to its precedence class, or CLS_NONE if not an operator.
// ----------------------------------------------------------------------------
module otl_classify (
    input  logic [20:0] code_point,
    output logic [3:0]  op_class
);
    import otl_pkg::*;

    // Table entries are distinct, so the matches are mutually exclusive.
    always_comb
    begin
        op_class = CLS_NONE;
        for (int i = 0; i < ASCII_OP_COUNT; i++)
        begin
            if (code_point == {14'd0, ASCII_OPS[i]})
            begin
                op_class = ASCII_CLS[i];
            end
        end
        for (int i = 0; i < UNI_OP_COUNT; i++)
        begin
            if (code_point == UNI_OPS[i])
            begin
                op_class = UNI_CLS[i];
            end
        end
    end

endmodule

### hdl/otl_scan.sv
// ----------------------------------------------------------------------------
// Operator scan state machine
// Holds the open scan and decides each request's effect in one pass.
// ----------------------------------------------------------------------------
module otl_scan #(
    parameter int unsigned MAX_LEN = 255
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_fire,
    input  otl_pkg::item_t  item,
    input  logic [3:0]      op_class,
    output otl_pkg::result_t res
);
    import otl_pkg::*;

    localparam logic [7:0] LEN_LIMIT = 8'((MAX_LEN > 255) ? 255 : MAX_LEN);

    logic       active_reg, active_next;
    phase_t     phase_reg, phase_next;
    logic [3:0] base_reg, base_next;
    logic       cmp_reg, cmp_next;
    flags_t     flags_reg, flags_next;
    logic [7:0] count_reg, count_next;

    logic       is_op;
    logic [7:0] count_inc;
    phase_t     phase_plain;
    logic       term_ok;
    logic [3:0] term_class;

    assign is_op     = (op_class != CLS_NONE);
    assign count_inc = (count_reg < LEN_LIMIT) ? count_reg + 8'd1 : count_reg;
    assign term_ok   = flags_reg.imm || (item.code_point == CH_SPACE) ||
                       (item.code_point == CH_LF) || (item.code_point == CH_CR);

    // Phase after an operator character seen from the regular phase.
    always_comb
    begin
        if ((item.code_point == CH_TILDE) || (item.code_point == CH_MINUS))
        begin
            phase_plain = PH_MAYBE_ARROW;
        end
        else if (item.code_point == CH_EQ)
        begin
            phase_plain = PH_ASSIGN;
        end
        else
        begin
            phase_plain = PH_REGULAR;
        end
    end

    always_comb
    begin
        term_class = base_reg;
        case (phase_reg)
            PH_ARROW:  term_class = CLS_OP0;
            PH_ASSIGN: term_class = cmp_reg ? base_reg : CLS_OP1;
            PH_EQUAL:  term_class = flags_reg.eq ? CLS_EQUAL : base_reg;
            PH_COLON:  term_class = flags_reg.col ? CLS_COLON : base_reg;
            default:   term_class = base_reg;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        base_next   = base_reg;
        cmp_next    = cmp_reg;
        flags_next  = flags_reg;
        count_next  = count_reg;
        res         = '0;

        if (item.start_req)
        begin
            active_next = 1'b1;
            flags_next  = '{imm: item.immediate, eq: item.equal_valid,
                            col: item.colon_valid};
            count_next  = 8'd1;
            base_next   = op_class;
            cmp_next    = (item.code_point == CH_LT) || (item.code_point == CH_GT) ||
                          (item.code_point == CH_BANG) || (item.code_point == CH_EQ) ||
                          (item.code_point == CH_TILDE) || (item.code_point == CH_QUEST);
            if (item.code_point == CH_DOT)
            begin
                phase_next = PH_MAYBE_DOT;
            end
            else if (item.code_point == CH_EQ)
            begin
                phase_next = PH_EQUAL;
            end
            else if (item.code_point == CH_COLON)
            begin
                phase_next = PH_COLON;
            end
            else
            begin
                phase_next = phase_plain;
            end
            if (!item.ops_all_valid || !is_op)
            begin
                active_next = 1'b0;
                res.emit    = 1'b1;
            end
        end
        else if (active_reg)
        begin
            if (is_op)
            begin
                count_next = count_inc;
                case (phase_reg)
                    PH_MAYBE_DOT:
                    begin
                        phase_next = PH_REGULAR;
                        if (item.code_point != CH_DOT)
                        begin
                            active_next = 1'b0;
                            res.emit    = 1'b1;
                        end
                    end
                    PH_ASSIGN, PH_EQUAL, PH_MAYBE_ARROW:
                    begin
                        phase_next = (item.code_point == CH_GT) ? PH_ARROW : phase_plain;
                    end
                    default:
                    begin
                        phase_next = phase_plain;
                    end
                endcase
            end
            else
            begin
                // A non-operator character ends the scan.
                active_next = 1'b0;
                res.emit    = 1'b1;
                if ((phase_reg != PH_MAYBE_DOT) && term_ok)
                begin
                    res.accepted     = 1'b1;
                    res.token_class  = term_class;
                    res.token_length = count_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= PH_REGULAR;
            base_reg   <= '0;
            cmp_reg    <= 1'b0;
            flags_reg  <= '0;
            count_reg  <= '0;
        end
        else if (item_fire)
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            base_reg   <= base_next;
            cmp_reg    <= cmp_next;
            flags_reg  <= flags_next;
            count_reg  <= count_next;
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operator token lexer testbench
// Drives directed and random character streams through the lexer, predicts
// each finished scan, and checks every token result field by field.
// ----------------------------------------------------------------------------
module tb;

    import otl_pkg::*;

    localparam int LEN_MAX   = 255;
    localparam int LEN_CAP   = (LEN_MAX > 255) ? 255 : LEN_MAX;
    localparam int ITEM_GOAL = 1700;

    typedef struct packed {
        logic       acc;
        logic [3:0] cls;
        logic [7:0] len;
    } tok_t;

    // One row of the directed stream; the expected token is typed in only
    // where the row has the typed bit set.
    typedef struct packed {
        logic        s;
        logic [20:0] cp;
        logic        imm;
        logic        ops;
        logic        eq;
        logic        col;
        logic        typed;
        logic        acc;
        logic [3:0]  cls;
        logic [7:0]  len;
    } row_t;

    localparam logic [20:0] OP_CHARS [40] = '{
        21'h24, 21'h5E, 21'h2A, 21'h25, 21'h5C, 21'h2F, 21'h2B, 21'h2D, 21'h7E, 21'h7C,
        21'h26, 21'h2E, 21'h3D, 21'h3C, 21'h3E, 21'h21, 21'h40, 21'h3A, 21'h3F,
        21'h02219, 21'h02218, 21'h000D7, 21'h02605, 21'h02297, 21'h02298, 21'h02299,
        21'h0229B, 21'h022A0, 21'h022A1, 21'h02229, 21'h02227, 21'h02293,
        21'h000B1, 21'h02295, 21'h02296, 21'h0229E, 21'h0229F, 21'h0222A, 21'h02228,
        21'h02294
    };
    // Characters that steer the phase machine, drawn more often.
    localparam logic [20:0] PHASE_CHARS [6] = '{
        21'h2E, 21'h3D, 21'h3A, 21'h3E, 21'h2D, 21'h7E
    };

    row_t dir_rows [26] = '{
        '{1'b0, 21'h2B, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h2B, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h61, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h2E, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h2B, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h2E, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h2E, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h2E, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h3D, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h3A, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h0A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h2D, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h3E, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h0D, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h2B, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h78, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h24, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h02219, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h000B1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h1FFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b1, 21'h3D, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h3D, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 21'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 8'd0}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        item_valid    = 1'b0;
    logic        item_stall;
    logic        start_req     = 1'b0;
    logic [20:0] code_point    = '0;
    logic        immediate     = 1'b0;
    logic        ops_all_valid = 1'b0;
    logic        equal_valid   = 1'b0;
    logic        colon_valid   = 1'b0;
    logic        result_valid;
    logic        result_stall  = 1'b0;
    logic        accepted;
    logic [3:0]  token_class;
    logic [7:0]  token_length;

    logic        hold_off      = 1'b0;
    int          send_idle     = 0;
    int          recv_idle     = 0;
    int          mismatches    = 0;
    tok_t        pending_tokens [$];

    // Shadow of the scanner state.
    logic        scan_on  = 1'b0;
    phase_t      scan_ph  = PH_REGULAR;
    logic [3:0]  lead_cls = '0;
    logic        lead_cmp = 1'b0;
    flags_t      scan_fl  = '0;
    logic [7:0]  tok_len  = '0;

    operator_token_lexer_top #(
        .MAX_LEN(LEN_MAX)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .start_req    (start_req),
        .code_point   (code_point),
        .immediate    (immediate),
        .ops_all_valid(ops_all_valid),
        .equal_valid  (equal_valid),
        .colon_valid  (colon_valid),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .accepted     (accepted),
        .token_class  (token_class),
        .token_length (token_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic logic [3:0] op_class(input logic [20:0] c);
        case (c)
            21'h24:                         return 4'd0;
            21'h5E:                         return 4'd1;
            21'h2A, 21'h25, 21'h5C, 21'h2F: return 4'd2;
            21'h2B, 21'h2D, 21'h7E, 21'h7C: return 4'd3;
            21'h26:                         return 4'd4;
            21'h2E:                         return 4'd5;
            21'h3D, 21'h3C, 21'h3E, 21'h21: return 4'd6;
            21'h40, 21'h3A, 21'h3F:         return 4'd7;
            21'h02219, 21'h02218, 21'h000D7, 21'h02605, 21'h02297, 21'h02298,
            21'h02299, 21'h0229B, 21'h022A0, 21'h022A1, 21'h02229, 21'h02227,
            21'h02293:                      return 4'd2;
            21'h000B1, 21'h02295, 21'h02296, 21'h0229E, 21'h0229F, 21'h0222A,
            21'h02228, 21'h02294:           return 4'd3;
            default:                        return CLS_NONE;
        endcase
    endfunction

    function automatic void bump_len();
        if (tok_len < 8'(LEN_CAP))
            tok_len++;
    endfunction

    // Moves the phase machine over one operator character; 0 means rejected.
    // A pending arrow phase that does not see '>' falls back to regular and
    // looks at the same character again.
    function automatic bit advance(input logic [20:0] c);
        int pass;
        for (pass = 0; pass < 2; pass++)
        begin
            case (scan_ph)
                PH_MAYBE_DOT:
                begin
                    if (c != CH_DOT)
                        return 1'b0;
                    scan_ph = PH_REGULAR;
                    bump_len();
                    return 1'b1;
                end
                PH_ASSIGN, PH_EQUAL, PH_MAYBE_ARROW:
                begin
                    if (c == CH_GT)
                    begin
                        scan_ph = PH_ARROW;
                        bump_len();
                        return 1'b1;
                    end
                    scan_ph = PH_REGULAR;
                end
                default:
                begin
                    if (c == CH_TILDE || c == CH_MINUS)
                        scan_ph = PH_MAYBE_ARROW;
                    else if (c == CH_EQ)
                        scan_ph = PH_ASSIGN;
                    else
                        scan_ph = PH_REGULAR;
                    bump_len();
                    return 1'b1;
                end
            endcase
        end
        return 1'b1;
    endfunction

    task automatic scan_char(input item_t it, output bit fire, output tok_t tok);
        logic [3:0] cls;
        fire = 1'b0;
        tok  = '0;
        if (it.start_req)
        begin
            scan_on = 1'b1;
            tok_len = '0;
            scan_ph = PH_REGULAR;
            scan_fl = '{it.immediate, it.equal_valid, it.colon_valid};
            cls     = op_class(it.code_point);
            if (!it.ops_all_valid || cls == CLS_NONE)
            begin
                fire    = 1'b1;
                scan_on = 1'b0;
                return;
            end
            lead_cls = cls;
            lead_cmp = it.code_point inside {CH_LT, CH_GT, CH_BANG, CH_EQ, CH_TILDE, CH_QUEST};
            if (it.code_point inside {CH_DOT, CH_EQ, CH_COLON})
            begin
                scan_ph = (it.code_point == CH_DOT) ? PH_MAYBE_DOT :
                          (it.code_point == CH_EQ)  ? PH_EQUAL : PH_COLON;
                bump_len();
                return;
            end
            if (!advance(it.code_point))
            begin
                fire    = 1'b1;
                scan_on = 1'b0;
            end
            return;
        end
        if (!scan_on)
            return;
        if (op_class(it.code_point) != CLS_NONE)
        begin
            if (!advance(it.code_point))
            begin
                fire    = 1'b1;
                scan_on = 1'b0;
            end
            return;
        end
        // A non-operator character ends the scan.
        fire    = 1'b1;
        scan_on = 1'b0;
        cls     = lead_cls;
        case (scan_ph)
            PH_ARROW:     cls = CLS_OP0;
            PH_ASSIGN:    if (!lead_cmp) cls = CLS_OP1;
            PH_EQUAL:     if (scan_fl.eq) cls = CLS_EQUAL;
            PH_COLON:     if (scan_fl.col) cls = CLS_COLON;
            PH_MAYBE_DOT: return;
            default:      ;
        endcase
        if (!scan_fl.imm && !(it.code_point inside {CH_SPACE, CH_LF, CH_CR}))
            return;
        tok = '{1'b1, cls, tok_len};
    endtask

    // Offers one request and waits until it is taken.
    task automatic push_req(input item_t it, input bit typed, input tok_t want);
        bit   fire;
        tok_t pred;
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        start_req     <= it.start_req;
        code_point    <= it.code_point;
        immediate     <= it.immediate;
        ops_all_valid <= it.ops_all_valid;
        equal_valid   <= it.equal_valid;
        colon_valid   <= it.colon_valid;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        scan_char(it, fire, pred);
        if (typed)
            pending_tokens.push_back(want);
        else if (fire)
            pending_tokens.push_back(pred);
    endtask

    function automatic logic [20:0] pick_op();
        if ($urandom_range(1))
            return PHASE_CHARS[$urandom_range(5)];
        return OP_CHARS[$urandom_range(39)];
    endfunction

    function automatic logic [20:0] pick_char();
        case ($urandom_range(3))
            0:       return 21'h0;
            1:       return 21'($urandom_range(127));
            2:       return 21'($urandom_range(21'h10FFFF));
            default: return pick_op();
        endcase
    endfunction

    always @(posedge clk)
    begin
        tok_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_tokens.size() == 0)
                flag_error("token result with none expected");
            else
            begin
                want = pending_tokens.pop_front();
                if (accepted !== want.acc)
                    flag_error($sformatf("accepted %0b, expected %0b", accepted, want.acc));
                if (token_class !== want.cls)
                    flag_error($sformatf("token_class %0d, expected %0d",
                                         token_class, want.cls));
                if (token_length !== want.len)
                    flag_error($sformatf("token_length %0d, expected %0d",
                                         token_length, want.len));
            end
        end
        result_stall <= hold_off || ($urandom_range(99) < recv_idle);
    end

    initial
    begin
        item_t       it;
        tok_t        want;
        row_t        row;
        int          n_items;
        int          kind;
        int          run_len;
        int          long_runs;
        int          spins;
        bit          long_run;
        logic [20:0] c;
        n_items   = 0;
        long_runs = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 18;
        recv_idle = 84;
        foreach (dir_rows[i])
        begin
            row  = dir_rows[i];
            it   = '{row.s, row.cp, row.imm, row.ops, row.eq, row.col};
            want = '{row.acc, row.cls, row.len};
            push_req(it, row.typed, want);
        end

        // Long receiver hold-off so the result side backs up into the input.
        fork
            begin
                hold_off <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none

        while (n_items < ITEM_GOAL)
        begin
            if (n_items >= 2 * ITEM_GOAL / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (n_items >= ITEM_GOAL / 3)
            begin
                send_idle = 84;
                recv_idle = 18;
            end
            kind = $urandom_range(99);
            if (kind < 5)
            begin
                // Stray character, usually ignored while idle.
                it = '{1'b0, pick_char(), 1'($urandom), 1'($urandom), 1'($urandom),
                       1'($urandom)};
                push_req(it, 1'b0, '0);
                continue;
            end
            long_run = (kind >= 97 && long_runs < 3);
            if (long_run)
            begin
                long_runs++;
                c = 21'h2B;
            end
            else
                c = ($urandom_range(19) == 0) ? pick_char() : pick_op();
            it = '{1'b1, c, 1'($urandom), 1'($urandom_range(15) != 0), 1'($urandom),
                   1'($urandom)};
            push_req(it, 1'b0, '0);
            n_items++;
            run_len = long_run ? $urandom_range(250, 300) : $urandom_range(4);
            for (int k = 0; k < run_len; k++)
            begin
                if (long_run)
                    c = PHASE_CHARS[3 + $urandom_range(2)];
                else
                    c = pick_op();
                it = '{1'b0, c, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)};
                push_req(it, 1'b0, '0);
                n_items++;
            end
            // A few scans are left open and cut off by the next start.
            if (kind >= 10)
            begin
                case ($urandom_range(9))
                    0, 1, 2: c = CH_SPACE;
                    3, 4:    c = CH_LF;
                    5, 6:    c = CH_CR;
                    default: c = pick_char();
                endcase
                it = '{1'b0, c, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)};
                push_req(it, 1'b0, '0);
                n_items++;
            end
        end
        item_valid <= 1'b0;

        spins = 0;
        while (pending_tokens.size() != 0 && spins < 20000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (10) @(posedge clk);
        if (pending_tokens.size() != 0)
            flag_error($sformatf("%0d token results never arrived", pending_tokens.size()));

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
